>>> design/mama_pkg.sv
// ---------------------------------------------------------------------------
// mama_pkg: shared types and constants
// Entry and result layouts, opcodes and scan states for the action matcher.
// ---------------------------------------------------------------------------
package mama_pkg;

    localparam int NUM_ACTIONS = 64;
    localparam int ATOM_BITS   = 64;
    localparam int WORD_W      = 64;
    localparam int COST_W      = 16;
    localparam int INDEX_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int POS_W       = $clog2(NUM_ACTIONS + 1);

    localparam logic [WORD_W-1:0] ATOM_MASK = {WORD_W{1'b1}} >> (WORD_W - ATOM_BITS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_ACTIONS_IN_USE = 1'b0;

    typedef struct packed {
        logic [WORD_W-1:0] pre_values;
        logic [WORD_W-1:0] pre_care;
        logic [WORD_W-1:0] post_values;
        logic [WORD_W-1:0] post_affected;
        logic [COST_W-1:0] cost;
    } t_entry;

    typedef struct packed {
        logic               match_valid;
        logic [INDEX_W-1:0] action_index;
        logic [COST_W-1:0]  action_cost;
        logic [WORD_W-1:0]  next_values;
        logic [WORD_W-1:0]  next_dontcare;
        logic               last;
    } t_result;

    typedef struct packed {
        logic shift;
    } t_ring_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

>>> design/mama_cell.sv
// ---------------------------------------------------------------------------
// mama_cell: one action entry of the ring
// Loads an entry on a write request, takes its neighbor's entry on a shift.
// ---------------------------------------------------------------------------
module mama_cell
    import mama_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_en,
    input  t_entry    i_wr_entry,
    input  t_ring_ctl i_ring,
    input  t_entry    i_neighbor,
    output t_entry    o_entry
);

    logic   r_valid;
    t_entry r_entry;

    // never-written entries read as all zero
    assign o_entry = r_valid ? r_entry : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en || i_ring.shift) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_entry;
        end else if (i_ring.shift) begin
            r_entry <= i_neighbor;
        end
    end

endmodule

>>> design/mama_ctrl.sv
// ---------------------------------------------------------------------------
// mama_ctrl: scan sequencer and result output
// Rotates the ring once per query, matches the head entry, holds one result
// back so the final one can carry last.
// ---------------------------------------------------------------------------
module mama_ctrl
    import mama_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic               i_opcode,
    input  logic [WORD_W-1:0]  i_state_values,
    input  logic [WORD_W-1:0]  i_state_dontcare,
    input  logic [COUNT_W-1:0] i_result_limit,
    input  logic [COUNT_W-1:0] i_actions_in_use,
    input  t_entry             i_head,
    input  logic               i_m_ready,
    output logic               o_s_ready,
    output t_ring_ctl          o_ring,
    output logic               o_m_valid,
    output t_result            o_m_result
);

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_scan, n_scan;
    logic [POS_W-1:0]  r_limit, n_limit;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic              r_pend_v, n_pend_v;
    logic              r_out_v, n_out_v;
    logic [WORD_W-1:0] r_sv, n_sv;
    logic [WORD_W-1:0] r_sd, n_sd;
    t_result           r_pend, n_pend;
    t_result           r_out, n_out;

    logic    out_free;
    logic    hit;
    logic    advance;
    t_result cand;

    assign out_free = !r_out_v || i_m_ready;
    assign advance  = !r_pend_v || out_free;

    assign hit = (r_pos < r_scan) && (r_cnt < r_limit)
              && (((i_head.pre_values ^ r_sv) & i_head.pre_care) == '0);

    always_comb begin
        cand               = '0;
        cand.match_valid   = 1'b1;
        cand.action_index  = INDEX_W'(r_pos);
        cand.action_cost   = i_head.cost;
        cand.next_values   = ((r_sv & ~i_head.post_affected)
                            | (i_head.post_values & i_head.post_affected)) & ATOM_MASK;
        cand.next_dontcare = r_sd & ~i_head.post_affected & ATOM_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_limit <= n_limit;
        r_sv    <= n_sv;
        r_sd    <= n_sd;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_scan       = r_scan;
        n_limit      = r_limit;
        n_cnt        = r_cnt;
        n_sv         = r_sv;
        n_sd         = r_sd;
        n_pend_v     = r_pend_v;
        n_pend       = r_pend;
        n_out_v      = r_out_v && !i_m_ready;
        n_out        = r_out;
        o_s_ready    = 1'b0;
        o_ring.shift = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid && (i_opcode == OP_QUERY)) begin
                    n_state = ST_SCAN;
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_sv    = i_state_values & ATOM_MASK;
                    n_sd    = i_state_dontcare & ATOM_MASK;
                    n_scan  = (i_actions_in_use > COUNT_W'(NUM_ACTIONS))
                            ? POS_W'(NUM_ACTIONS) : POS_W'(i_actions_in_use);
                    n_limit = (i_result_limit > COUNT_W'(NUM_ACTIONS))
                            ? POS_W'(NUM_ACTIONS) : POS_W'(i_result_limit);
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    o_ring.shift = 1'b1;
                    n_pos        = r_pos + 1'b1;
                    if (hit) begin
                        n_cnt    = r_cnt + 1'b1;
                        n_pend_v = 1'b1;
                        n_pend   = cand;
                        // the earlier match is known not to be last now
                        if (r_pend_v) begin
                            n_out_v = 1'b1;
                            n_out   = r_pend;
                        end
                    end
                    if (r_pos == POS_W'(NUM_ACTIONS - 1)) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_v  = 1'b1;
                    n_out    = r_pend_v ? r_pend : '0;
                    n_out.last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_valid  = r_out_v;
    assign o_m_result = r_out;

endmodule

>>> design/masked_action_match_apply.sv
// ---------------------------------------------------------------------------
// masked_action_match_apply: action table with masked match and apply
// Ring of action cells scanned per query; emits each matching action, up to
// the result limit, with its successor state, or one no-match result.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                      content
//  s_*       in   s_tvalid / s_tready            write entry or query request
//  m_*       out  m_tvalid / m_tready            one result, m_tlast on final
//  apb       in   psel, penable, pwrite, pready  actions_in_use at 0x0
//
//  Write requests are taken back to back in idle. A query is taken in idle,
//  then rotates the ring once: NUM_ACTIONS shifts in the scan state, then
//  one flush. A shift or the flush waits while m_tready is low with a
//  result waiting. The next request is taken once the final result has
//  moved to the output register.
//  Reset empties every cell through its valid bit at once; no clearing pass.
// ---------------------------------------------------------------------------
module masked_action_match_apply
    import mama_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [5:0] entry_index, [69:6] pre_values, [133:70] pre_care,
    // [197:134] post_values, [261:198] post_affected, [277:262] cost_in,
    // [341:278] state_values, [405:342] state_dontcare,
    // [412:406] result_limit, [415:413] zero
    input  logic [415:0] s_tdata,
    // [0] opcode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] action_index, [21:6] action_cost, [85:22] next_values,
    // [149:86] next_dontcare, [151:150] zero
    output logic [151:0] m_tdata,
    // [0] match_valid
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [COUNT_W-1:0] r_actions_in_use;
    logic               s_accept;
    t_entry             wr_entry;
    t_entry             cells [NUM_ACTIONS];
    t_ring_ctl          ring;
    t_result            result;

    // configuration
    assign pready = 1'b1;
    assign prdata = {{(32 - COUNT_W){1'b0}}, r_actions_in_use};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_actions_in_use <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_ACTIONS_IN_USE)) begin
            r_actions_in_use <= pwdata[COUNT_W-1:0];
        end
    end

    assign s_accept = s_tvalid && s_tready;

    assign wr_entry.pre_values    = s_tdata[69:6]    & ATOM_MASK;
    assign wr_entry.pre_care      = s_tdata[133:70]  & ATOM_MASK;
    assign wr_entry.post_values   = s_tdata[197:134] & ATOM_MASK;
    assign wr_entry.post_affected = s_tdata[261:198] & ATOM_MASK;
    assign wr_entry.cost          = s_tdata[277:262];

    // cell 0 is the head; each shift moves every entry one place toward it
    for (genvar k = 0; k < NUM_ACTIONS; k++) begin : g_cell
        localparam int NEIGHBOR = (k + 1) % NUM_ACTIONS;
        logic wr_en;

        assign wr_en = s_accept && (s_tuser[0] == OP_WRITE)
                    && (s_tdata[INDEX_W-1:0] == INDEX_W'(k));

        mama_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (wr_en),
            .i_wr_entry (wr_entry),
            .i_ring     (ring),
            .i_neighbor (cells[NEIGHBOR]),
            .o_entry    (cells[k])
        );
    end

    mama_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_valid        (s_tvalid),
        .i_opcode         (s_tuser[0]),
        .i_state_values   (s_tdata[341:278]),
        .i_state_dontcare (s_tdata[405:342]),
        .i_result_limit   (s_tdata[412:406]),
        .i_actions_in_use (r_actions_in_use),
        .i_head           (cells[0]),
        .i_m_ready        (m_tready),
        .o_s_ready        (s_tready),
        .o_ring           (ring),
        .o_m_valid        (m_tvalid),
        .o_m_result       (result)
    );

    assign m_tdata = {2'b00, result.next_dontcare, result.next_values,
                      result.action_cost, result.action_index};
    assign m_tuser = result.match_valid;
    assign m_tlast = result.last;

endmodule

>>> design/mama_chk.sv
// ---------------------------------------------------------------------------
// mama_chk: port-level checks
// Result framing, stall behavior and register readback of the matcher.
// ---------------------------------------------------------------------------
module mama_chk
    import mama_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [2:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata
);

    // a query still has results to come: no new request taken
    a_busy_mid_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("request taken while a query is unfinished");

    // a no-match result is the only one of its query and carries zeros
    a_no_match_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
        else $error("malformed no-match result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    a_reg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_ACTIONS_IN_USE))
        |=> (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0])))
        else $error("actions_in_use readback mismatch");

endmodule

bind masked_action_match_apply mama_chk u_mama_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: masked_action_match_apply
// Loads action entries and queries world states over the stream port. A
// local copy of the action table works out the successor results of each
// accepted query; results are checked field by field in arrival order.
// ---------------------------------------------------------------------------
module testbench;
    import mama_pkg::*;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 44;
    localparam int HOLD_PHASE    = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = NUM_ACTIONS + 16;

    localparam logic [2:0]        SCAN_ADDR = {REG_ACTIONS_IN_USE, 2'b00};
    localparam logic [WORD_W-1:0] ONES      = '1;

    typedef struct {
        logic               opcode;
        logic [INDEX_W-1:0] entry_index;
        t_entry             entry;
        logic [WORD_W-1:0]  state_values;
        logic [WORD_W-1:0]  state_dontcare;
        logic [COUNT_W-1:0] result_limit;
    } t_request;

    typedef struct {
        bit                 set_scan;
        logic [COUNT_W-1:0] scan_value;
        t_request           req;
        bit                 typed;
        t_result            want;
    } t_vector;

    localparam t_result NO_MATCH = '{1'b0, '0, '0, '0, '0, 1'b1};

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [415:0] s_tdata;   // entry_index, pre_values, pre_care, post_values,
                             // post_affected, cost_in, state_values,
                             // state_dontcare, result_limit, zero pad
    logic [0:0]   s_tuser;   // opcode
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;   // action_index, action_cost, next_values,
                             // next_dontcare, zero pad
    logic [0:0]   m_tuser;   // match_valid
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    t_entry             action_mirror [NUM_ACTIONS];
    logic [COUNT_W-1:0] scan_length;
    t_result            pending_successors [$];
    int                 mismatches;
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    int                 rx_hold_req;

    masked_action_match_apply i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic check_word(input string what, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Table update on a write, successor list on a query.
    function automatic void predict_successors(input t_request r);
        int      scan;
        int      limit;
        int      hits;
        t_entry  e;
        t_result res;
        if (r.opcode == OP_WRITE) begin
            e = r.entry;
            e.pre_values    = e.pre_values & ATOM_MASK;
            e.pre_care      = e.pre_care & ATOM_MASK;
            e.post_values   = e.post_values & ATOM_MASK;
            e.post_affected = e.post_affected & ATOM_MASK;
            action_mirror[r.entry_index] = e;
            return;
        end
        scan  = (scan_length > NUM_ACTIONS) ? NUM_ACTIONS : int'(scan_length);
        limit = (r.result_limit > NUM_ACTIONS) ? NUM_ACTIONS : int'(r.result_limit);
        hits  = 0;
        for (int i = 0; i < scan && hits < limit; i++) begin
            e = action_mirror[i];
            if (((e.pre_values ^ r.state_values) & e.pre_care) == '0) begin
                res.match_valid   = 1'b1;
                res.action_index  = INDEX_W'(i);
                res.action_cost   = e.cost;
                res.next_values   = ((r.state_values & ~e.post_affected)
                                    | (e.post_values & e.post_affected)) & ATOM_MASK;
                res.next_dontcare = r.state_dontcare & ~e.post_affected & ATOM_MASK;
                res.last          = 1'b0;
                pending_successors.push_back(res);
                hits++;
            end
        end
        if (hits == 0) begin
            pending_successors.push_back(NO_MATCH);
        end else begin
            res = pending_successors.pop_back();
            res.last = 1'b1;
            pending_successors.push_back(res);
        end
    endfunction

    function automatic logic [415:0] pack_request(input t_request r);
        return {3'b000, r.result_limit, r.state_dontcare, r.state_values, r.entry.cost,
                r.entry.post_affected, r.entry.post_values, r.entry.pre_care,
                r.entry.pre_values, r.entry_index};
    endfunction

    function automatic t_request entry_req(input logic [INDEX_W-1:0] idx,
                                           input logic [WORD_W-1:0] pv, pc, ev, ea,
                                           input logic [COST_W-1:0] cost);
        t_request r;
        r.opcode         = OP_WRITE;
        r.entry_index    = idx;
        r.entry          = '{pv, pc, ev, ea, cost};
        r.state_values   = '0;
        r.state_dontcare = '0;
        r.result_limit   = '0;
        return r;
    endfunction

    function automatic t_request query_req(input logic [WORD_W-1:0] sv, sd,
                                           input logic [COUNT_W-1:0] limit);
        t_request r;
        r.opcode         = OP_QUERY;
        r.entry_index    = '0;
        r.entry          = '0;
        r.state_values   = sv;
        r.state_dontcare = sd;
        r.result_limit   = limit;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] rand_mask();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return ONES;
        if (pick < 30)
            return rand_word();
        // a handful of bits set
        return rand_word() & rand_word() & rand_word() & rand_word();
    endfunction

    function automatic t_request random_request();
        t_request r;
        t_entry   src;
        int       pick;
        int       span;
        r.entry          = '{rand_word(), rand_mask(), rand_word(), rand_mask(),
                             COST_W'($urandom)};
        r.entry_index    = INDEX_W'($urandom);
        r.state_values   = rand_word();
        r.state_dontcare = rand_word();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.result_limit = '0;
        else if (pick < 65)
            r.result_limit = COUNT_W'($urandom_range(1, 8));
        else if (pick < 88)
            r.result_limit = COUNT_W'($urandom_range(9, NUM_ACTIONS));
        else
            r.result_limit = COUNT_W'($urandom_range(NUM_ACTIONS + 1, 127));
        if ($urandom_range(0, 99) < 35) begin
            r.opcode = OP_WRITE;
        end else begin
            r.opcode = OP_QUERY;
            if ($urandom_range(0, 99) < 70) begin
                // aim the state at one scanned entry so it is sure to match
                span = (scan_length >= 1 && scan_length < NUM_ACTIONS)
                       ? int'(scan_length) : NUM_ACTIONS;
                src  = action_mirror[$urandom_range(0, span - 1)];
                r.state_values = (src.pre_values & src.pre_care)
                                 | (r.state_values & ~src.pre_care);
            end
        end
        return r;
    endfunction

    task automatic push_request(input t_request r, input bit typed = 1'b0,
                                input t_result want = NO_MATCH);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(r);
        s_tuser  <= r.opcode;
        do @(posedge i_clk); while (!s_tready);
        if (typed)
            pending_successors.push_back(want);
        else
            predict_successors(r);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_successors.size() != 0)
            @(posedge i_clk);
        // a write request may still be in flight with nothing expected
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_scan_length(input logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SCAN_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scan_length = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_word("actions_in_use readback", 64'(value), 64'(prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic change_scan_length(input logic [COUNT_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        write_scan_length(value);
    endtask

    task automatic run_directed();
        t_vector vectors [$];
        // reset table: every entry checks nothing and changes nothing
        vectors.push_back('{1'b1, 7'd0, query_req('0, '0, 7'd64), 1'b1, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, query_req(ONES, ONES, 7'd127), 1'b1, NO_MATCH});
        vectors.push_back('{1'b1, 7'd64, query_req(ONES, ONES, 7'd1), 1'b1,
                            '{1'b1, 6'd0, 16'h0000, ONES, ONES, 1'b1}});
        vectors.push_back('{1'b0, 7'd0, query_req(64'h0123_4567_89AB_CDEF,
                            64'hFEDC_BA98_7654_3210, 7'd0), 1'b1, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, query_req(64'h0123_4567_89AB_CDEF,
                            64'hF0F0_F0F0_0F0F_0F0F, 7'd64), 1'b0, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, entry_req(6'd0, ONES, ONES, '0, ONES, 16'hFFFF),
                            1'b0, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, entry_req(6'd63, '0, ONES, ONES, ONES, 16'h0000),
                            1'b0, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, entry_req(6'd1, 64'h5555_5555_5555_5555, '0,
                            64'hAAAA_AAAA_AAAA_AAAA, '0, 16'h0001), 1'b0, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, entry_req(6'd2, 64'hA5A5_A5A5_A5A5_A5A5,
                            64'hFFFF_FFFF_0000_0000, 64'h3C3C_3C3C_3C3C_3C3C,
                            64'h0000_0000_FFFF_FFFF, 16'h8000), 1'b0, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, query_req(ONES, ONES, 7'd64), 1'b0, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, query_req('0, ONES, 7'd127), 1'b0, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, query_req(ONES, ONES, 7'd1), 1'b1,
                            '{1'b1, 6'd0, 16'hFFFF, '0, '0, 1'b1}});
        // scan length past the table end
        vectors.push_back('{1'b1, 7'd127, query_req(64'hA5A5_A5A5_0000_0000,
                            64'h1234_5678_9ABC_DEF0, 7'd127), 1'b0, NO_MATCH});
        vectors.push_back('{1'b1, 7'd1, query_req('0, ONES, 7'd64), 1'b1, NO_MATCH});
        vectors.push_back('{1'b0, 7'd0, query_req(ONES, ONES, 7'd64), 1'b1,
                            '{1'b1, 6'd0, 16'hFFFF, '0, '0, 1'b1}});
        foreach (vectors[i]) begin
            if (vectors[i].set_scan)
                change_scan_length(vectors[i].scan_value);
            push_request(vectors[i].req, vectors[i].typed, vectors[i].want);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        int hold_seen;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != rx_hold_req) begin
                hold_seen = rx_hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_successors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid %b index %0d last %b",
                             m_tuser[0], m_tdata[5:0], m_tlast);
            end else begin
                want = pending_successors.pop_front();
                check_word("match_valid", 64'(want.match_valid), 64'(m_tuser[0]));
                check_word("action_index", 64'(want.action_index), 64'(m_tdata[5:0]));
                check_word("action_cost", 64'(want.action_cost), 64'(m_tdata[21:6]));
                check_word("next_values", want.next_values, m_tdata[85:22]);
                check_word("next_dontcare", want.next_dontcare, m_tdata[149:86]);
                check_word("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] scan_plan [PHASES];
        int                 phase_tx [PHASES];
        int                 phase_rx [PHASES];
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_rst_n      = 1'b0;
        mismatches   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 0;
        scan_length  = '0;
        foreach (action_mirror[i])
            action_mirror[i] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        scan_plan = '{7'd64, 7'd127, COUNT_W'($urandom_range(2, 63)), 7'd64, 7'd64,
                      COUNT_W'($urandom_range(1, 127))};
        phase_tx  = '{0, 48, 0, 25, 0, 25};
        phase_rx  = '{0, 0, 48, 25, 0, 25};
        for (int p = 0; p < PHASES; p++) begin
            change_scan_length(scan_plan[p]);
            tx_idle_pct  = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            // long receiver hold-off while requests keep coming
            if (p == HOLD_PHASE)
                rx_hold_req++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_request(random_request());
        end
        s_tvalid <= 1'b0;
        wait_drained();

        if (mismatches == 0 && pending_successors.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
